### rtl/utf16_newline_converter_assert.svh
// ----------------------------------------------------------------------------
// utf16 newline converter assertion macros
// shared property forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef UTF16_NEWLINE_CONVERTER_ASSERT_SVH
`define UTF16_NEWLINE_CONVERTER_ASSERT_SVH

// same-cycle implication
`define U16NL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u16nl assertion failed");

// next-cycle implication
`define U16NL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u16nl assertion failed");

`endif

### rtl/u16nl_pkg.sv
// ----------------------------------------------------------------------------
// u16nl_pkg
// types and constants of the utf16 newline converter
// ----------------------------------------------------------------------------
package u16nl_pkg;

  localparam logic [1:0] CONV_CRLF = 2'd0;
  localparam logic [1:0] CONV_CR   = 2'd1;
  localparam logic [1:0] CONV_LF   = 2'd2;

  localparam logic [1:0] CFG_SOURCE = 2'd0;
  localparam logic [1:0] CFG_DEST   = 2'd1;
  localparam logic [1:0] CFG_SWAP   = 2'd2;

  localparam logic [7:0] BOM_FIRST  = 8'hff;
  localparam logic [7:0] BOM_SECOND = 8'hfe;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic [7:0] in_first;
    logic [7:0] in_second;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } unit_t;

  typedef struct packed {
    logic [1:0] source_convention;
    logic [1:0] dest_convention;
    logic       swap_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    unit_t      u0;
    unit_t      u1;
  } job_t;

  function automatic unit_t char_unit(input logic be, input logic [7:0] ch);
    unit_t u;
    if (be) begin
      u.first  = CHAR_NUL;
      u.second = ch;
    end else begin
      u.first  = ch;
      u.second = CHAR_NUL;
    end
    return u;
  endfunction

  function automatic unit_t swap_unit(input logic sw, input unit_t u);
    unit_t r;
    if (sw) begin
      r.first  = u.second;
      r.second = u.first;
    end else begin
      r = u;
    end
    return r;
  endfunction

endpackage

### rtl/u16nl_cfg.sv
// ----------------------------------------------------------------------------
// u16nl_cfg
// configuration registers written over the cfg channel
// ----------------------------------------------------------------------------
module u16nl_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [1:0]      cfg_data,
  output u16nl_pkg::cfg_t cfg
);
  import u16nl_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SOURCE: cfg_r.source_convention <= cfg_data;
        CFG_DEST:   cfg_r.dest_convention   <= cfg_data;
        CFG_SWAP:   cfg_r.swap_bytes        <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/u16nl_conv.sv
// ----------------------------------------------------------------------------
// u16nl_conv
// byte order detection, newline conversion and pending cr state
// ----------------------------------------------------------------------------
module u16nl_conv (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  u16nl_pkg::in_item_t in_data,
  input  u16nl_pkg::cfg_t   cfg,
  output u16nl_pkg::job_t   job
);
  import u16nl_pkg::*;

  logic  bom_seen_r;
  logic  big_endian_r;
  logic  cr_pending_r;
  logic  cr_pending_nxt;
  logic  be;
  logic  is_cr;
  logic  is_lf;
  logic  act;
  logic  eos;
  unit_t raw;
  unit_t ucr;
  unit_t ulf;
  unit_t u0;
  unit_t u1;
  logic [1:0] cnt;

  assign raw = '{first: in_data.in_first, second: in_data.in_second};
  assign eos = in_data.end_of_stream;
  assign be  = bom_seen_r ? big_endian_r :
               !(raw.first == BOM_FIRST && raw.second == BOM_SECOND);
  assign ucr = char_unit(be, CHAR_CR);
  assign ulf = char_unit(be, CHAR_LF);
  assign is_cr = (raw == ucr);
  assign is_lf = (raw == ulf);
  assign act = (cfg.source_convention != cfg.dest_convention) &&
               (cfg.source_convention <= CONV_LF) && (cfg.dest_convention <= CONV_LF);

  always_comb begin
    cnt            = 2'd1;
    u0             = raw;
    u1             = raw;
    cr_pending_nxt = 1'b0;
    if (cr_pending_r) begin
      if (is_lf) begin
        if (cfg.dest_convention == CONV_CR) begin
          u0 = ucr;
        end else if (cfg.dest_convention == CONV_LF) begin
          u0 = ulf;
        end else begin
          cnt = 2'd2;
          u0  = ucr;
          u1  = ulf;
        end
      end else begin
        u0 = ucr;
        if (is_cr && act && cfg.source_convention == CONV_CRLF && !eos) begin
          cr_pending_nxt = 1'b1;
        end else begin
          cnt = 2'd2;
        end
      end
    end else if (act && is_cr) begin
      if (cfg.source_convention == CONV_CRLF) begin
        if (eos) begin
          u0 = ucr;
        end else begin
          cnt            = 2'd0;
          cr_pending_nxt = 1'b1;
        end
      end else if (cfg.source_convention == CONV_CR) begin
        if (cfg.dest_convention == CONV_CRLF) begin
          cnt = 2'd2;
          u0  = ucr;
          u1  = ulf;
        end else begin
          u0 = ulf;
        end
      end
    end else if (act && is_lf && cfg.source_convention == CONV_LF) begin
      u0 = ucr;
      if (cfg.dest_convention == CONV_CRLF) begin
        cnt = 2'd2;
        u1  = ulf;
      end
    end
  end

  assign job.cnt = cnt;
  assign job.u0  = swap_unit(cfg.swap_bytes, u0);
  assign job.u1  = swap_unit(cfg.swap_bytes, u1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bom_seen_r   <= 1'b0;
      big_endian_r <= 1'b1;
      cr_pending_r <= 1'b0;
    end else if (in_fire) begin
      bom_seen_r   <= 1'b1;
      big_endian_r <= be;
      cr_pending_r <= cr_pending_nxt;
    end
  end

  `include "utf16_newline_converter_assert.svh"

  `U16NL_ASSERT_IMP(a_pending_after_bom, cr_pending_r, bom_seen_r)
  `U16NL_ASSERT_NXT(a_silent_means_held, in_fire && job.cnt == 2'd0, cr_pending_r)

endmodule

### rtl/u16nl_obuf.sv
// ----------------------------------------------------------------------------
// u16nl_obuf
// result register holding up to two units and draining one per transfer
// ----------------------------------------------------------------------------
module u16nl_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  u16nl_pkg::job_t    job,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output u16nl_pkg::out_item_t out_data
);
  import u16nl_pkg::*;

  logic  valid_r;
  logic  two_r;
  logic  idx_r;
  unit_t u0_r;
  unit_t u1_r;
  unit_t cur;
  logic  last;
  logic  drain;

  assign last  = !two_r || idx_r;
  assign drain = valid_r && out_ready && last;
  assign free  = !valid_r || drain;

  assign cur                 = idx_r ? u1_r : u0_r;
  assign out_valid           = valid_r;
  assign out_data.out_first  = cur.first;
  assign out_data.out_second = cur.second;
  assign out_data.last_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      two_r   <= 1'b0;
      idx_r   <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      two_r   <= (job.cnt == 2'd2);
      idx_r   <= 1'b0;
    end else if (drain) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (valid_r && out_ready) begin
      idx_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      u0_r <= job.u0;
      u1_r <= job.u1;
    end
  end

  `include "utf16_newline_converter_assert.svh"

  `U16NL_ASSERT_IMP(a_second_slot_only_for_pair, idx_r, two_r && valid_r)
  `U16NL_ASSERT_NXT(a_pair_shows_first_half, load && job.cnt == 2'd2,
                    out_valid && !out_data.last_of_run)

endmodule

### rtl/utf16_newline_converter.sv
// ----------------------------------------------------------------------------
// utf16_newline_converter
// utf16 line ending converter with byte order detection and optional swap
// ----------------------------------------------------------------------------
// One code unit is taken per cycle while the result register is free, and is
// converted in a single pass into a result register, which presents the first
// result unit in the cycle after the input transfer. An item that yields two
// units (a line ending expanded to CR LF, or a held CR released ahead of the
// unit that follows it) holds the result register for two output transfers and
// stalls the input until the second of them is being transferred. A CR held for
// look-ahead yields no unit until the next item. Configuration is written one
// register per transfer on the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module utf16_newline_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u16nl_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16nl_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [1:0]           cfg_data
);
  import u16nl_pkg::*;

  cfg_t cfg;
  job_t job;
  logic free;
  logic in_fire;

  assign in_ready = free;
  assign in_fire  = in_valid && free;

  u16nl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  u16nl_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .cfg     (cfg),
    .job     (job)
  );

  u16nl_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && job.cnt != 2'd0),
    .job       (job),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
